### rtl/bb3_pkg.sv
`default_nettype none
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W        = 24;
  localparam int CH_W         = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;
  localparam int ROW_W        = 16;
  localparam int IDX_W        = 26;
  localparam int OROW_W       = 17;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int RECIP_W      = 16;
  localparam int RECIP_SH     = 15;

  localparam logic [CFG_IDX_W-1:0]    REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]    REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET      = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET     = 16'd480;

  localparam logic [ROW_W-1:0]  ROW_MAX  = 16'hFFFF;
  localparam logic [OROW_W-1:0] OROW_SAT = 17'h10000;

  // Reciprocals scaled by two to the fifteenth; exact for sums below 4096.
  localparam logic [RECIP_W-1:0] RECIP_ONE   = 16'd32768;
  localparam logic [RECIP_W-1:0] RECIP_THREE = 16'd10923;
  localparam logic [RECIP_W-1:0] RECIP_NINE  = 16'd3641;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_pixel;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic sum;
    logic load_out;
    logic div_start;
    logic div_step;
    logic div_commit;
  } bb3_cmd_t;

  typedef struct packed {
    logic due;
  } bb3_stat_t;

  function automatic logic [CH_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                              input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0]         x;
    logic [RECIP_W-1:0]       m;
    logic [SUM_W+RECIP_W-1:0] prod;
    x = sum;
    m = RECIP_ONE;
    case (cnt)
      4'd1: begin
        x = sum;
        m = RECIP_ONE;
      end
      4'd2: begin
        x = sum >> 1;
        m = RECIP_ONE;
      end
      4'd3: begin
        x = sum;
        m = RECIP_THREE;
      end
      4'd4: begin
        x = sum >> 2;
        m = RECIP_ONE;
      end
      4'd6: begin
        x = sum >> 1;
        m = RECIP_THREE;
      end
      4'd9: begin
        x = sum;
        m = RECIP_NINE;
      end
      default: begin
        x = '0;
        m = '0;
      end
    endcase
    prod = (SUM_W+RECIP_W)'(x) * (SUM_W+RECIP_W)'(m);
    return prod[RECIP_SH +: CH_W];
  endfunction

endpackage
`default_nettype wire

### rtl/bb3_ram.sv
`default_nettype none
module bb3_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/bb3_ctrl.sv
`default_nettype none
module bb3_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire logic                cfg_we,
  input  wire bb3_pkg::bb3_stat_t  stat,
  output bb3_pkg::bb3_cmd_t        cmd
);

  localparam int STEP_W = $clog2(bb3_pkg::IDX_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(bb3_pkg::IDX_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_MEAN,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              pend_r, pend_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r | cfg_we;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          cmd.div_start = 1'b1;
          pend_nxt      = cfg_we;
          step_nxt      = '0;
          state_nxt     = S_DIV;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = stat.due ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.div_commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE) && !pend_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/bb3_dp.sv
`default_nettype none
module bb3_dp #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bb3_pkg::in_word_t                in_data,
  input  wire logic                             cfg_we,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire bb3_pkg::bb3_cmd_t                cmd,
  output bb3_pkg::bb3_stat_t                    stat,
  output bb3_pkg::out_word_t                    out_data
);

  localparam int CB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB  = ($clog2(MAX_WIDTH + 1) > bb3_pkg::CFG_WIDTH_W) ?
                       $clog2(MAX_WIDTH + 1) : bb3_pkg::CFG_WIDTH_W;
  localparam int WX  = WB + 1;
  localparam int TB  = WB + bb3_pkg::CFG_HEIGHT_W;
  localparam int KB  = bb3_pkg::IDX_W;
  localparam int RB  = bb3_pkg::OROW_W;
  localparam int RX  = RB + 1;
  localparam int PW  = bb3_pkg::PIX_W;
  localparam int CW  = bb3_pkg::CH_W;
  localparam int SW  = bb3_pkg::SUM_W;
  localparam int NW  = bb3_pkg::CNT_W;
  localparam int HW  = bb3_pkg::CFG_HEIGHT_W;

  logic [bb3_pkg::CFG_WIDTH_W-1:0] width_raw_r;
  logic [HW-1:0]                   height_raw_r;
  logic [WB-1:0]                   wc;
  logic [HW-1:0]                   hc;
  logic [TB-1:0]                   total_r;

  logic [CB-1:0]                   col_r, col_nxt;
  logic [bb3_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [CB-1:0]                   wr_col_r;
  logic [PW-1:0]                   px_r;
  logic                            due_r;
  logic                            due;
  logic                            col_wrap;

  logic [KB-1:0]                   k_r, k_nxt;
  logic [RB-1:0]                   orow_r, orow_nxt;
  logic [CB-1:0]                   ocol_r, ocol_nxt;
  logic                            ocol_wrap;

  logic [PW-1:0]                   win_r [9];
  logic [PW-1:0]                   older_rd, newer_rd;

  logic [2:0]                      row_ok, col_ok;
  logic [8:0]                      mask;
  logic [SW-1:0]                   acc [3];
  logic [SW-1:0]                   sum_r [3];
  logic [NW-1:0]                   cnt_r;
  logic                            last, last_r;

  logic [KB-1:0]                   dq_r;
  logic [WB-1:0]                   drem_r;
  logic [WX-1:0]                   dshift, dsub;
  logic                            dbit;

  bb3_pkg::out_word_t              out_r;

  always_comb begin
    if (width_raw_r == '0) begin
      wc = WB'(1);
    end else if (WB'(width_raw_r) > WB'(MAX_WIDTH)) begin
      wc = WB'(MAX_WIDTH);
    end else begin
      wc = WB'(width_raw_r);
    end
  end

  assign hc = (height_raw_r == '0) ? HW'(1) : height_raw_r;

  assign due      = (row_r >= 16'd2) || ((row_r == 16'd1) && (col_r != '0));
  assign col_wrap = (WX'(col_r) + WX'(1)) >= WX'(wc);

  assign row_ok[0] = (orow_r != '0);
  assign row_ok[1] = (orow_r < RB'(hc));
  assign row_ok[2] = (RX'(orow_r) + RX'(1)) < RX'(hc);
  assign col_ok[0] = (ocol_r != '0);
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = (WX'(ocol_r) + WX'(1)) < WX'(wc);

  assign ocol_wrap = (WX'(ocol_r) + WX'(1)) >= WX'(wc);
  assign last      = (TB'(k_r) + TB'(1)) >= total_r;

  always_comb begin
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        mask[dr*3+dc] = row_ok[dr] & col_ok[dc];
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = '0;
      for (int i = 0; i < 9; i++) begin
        if (mask[i]) begin
          acc[ch] = acc[ch] + SW'(win_r[i][ch*CW +: CW]);
        end
      end
    end
  end

  assign dshift = {drem_r, dq_r[KB-1]};
  assign dbit   = (dshift >= WX'(wc));
  assign dsub   = dbit ? (dshift - WX'(wc)) : dshift;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    k_nxt    = k_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    if (cmd.accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        if (row_r != bb3_pkg::ROW_MAX) begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cmd.sum) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        k_nxt    = '0;
        orow_nxt = '0;
        ocol_nxt = '0;
      end else if (k_r == '1) begin
        k_nxt    = '0;
        orow_nxt = '0;
        ocol_nxt = '0;
      end else begin
        k_nxt = k_r + 1'b1;
        if (ocol_wrap) begin
          ocol_nxt = '0;
          if (orow_r != bb3_pkg::OROW_SAT) begin
            orow_nxt = orow_r + 1'b1;
          end
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
    end
    if (cmd.div_commit) begin
      orow_nxt = (dq_r > KB'(bb3_pkg::OROW_SAT)) ? bb3_pkg::OROW_SAT : dq_r[RB-1:0];
      ocol_nxt = CB'(drem_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= bb3_pkg::WIDTH_RESET;
      height_raw_r <= bb3_pkg::HEIGHT_RESET;
      col_r        <= '0;
      row_r        <= '0;
      k_r          <= '0;
      orow_r       <= '0;
      ocol_r       <= '0;
      due_r        <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bb3_pkg::REG_IMAGE_WIDTH:  width_raw_r  <= cfg_data[bb3_pkg::CFG_WIDTH_W-1:0];
          bb3_pkg::REG_IMAGE_HEIGHT: height_raw_r <= cfg_data[HW-1:0];
          default: ;
        endcase
      end
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      k_r    <= k_nxt;
      orow_r <= orow_nxt;
      ocol_r <= ocol_nxt;
      if (cmd.accept) begin
        due_r <= due;
      end
      if (cmd.shift) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= older_rd;
        win_r[5] <= newer_rd;
        win_r[8] <= px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TB'(wc) * TB'(hc);
    if (cmd.accept) begin
      wr_col_r <= col_r;
      px_r     <= in_data.kind ? '0 : {in_data.blue_in, in_data.green_in, in_data.red_in};
    end
    if (cmd.sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_r[ch] <= acc[ch];
      end
      cnt_r  <= NW'($countones(mask));
      last_r <= last;
    end
    if (cmd.load_out) begin
      out_r.red_out    <= bb3_pkg::mean_of(sum_r[0], cnt_r);
      out_r.green_out  <= bb3_pkg::mean_of(sum_r[1], cnt_r);
      out_r.blue_out   <= bb3_pkg::mean_of(sum_r[2], cnt_r);
      out_r.last_pixel <= last_r;
    end
    if (cmd.div_start) begin
      dq_r   <= k_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[KB-2:0], dbit};
      drem_r <= dsub[WB-1:0];
    end
  end

  bb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_older_row (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (wr_col_r),
    .wdata (newer_rd),
    .re    (cmd.accept),
    .raddr (col_r),
    .rdata (older_rd)
  );

  bb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_newer_row (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (wr_col_r),
    .wdata (px_r),
    .re    (cmd.accept),
    .raddr (col_r),
    .rdata (newer_rd)
  );

  assign stat.due = due_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

### rtl/box_blur_3x3_rgb.sv
`default_nettype none
// Channel   Handshake               Payload
// in        in_valid / in_ready     in_data   (kind, red_in, green_in, blue_in)
// out       out_valid / out_ready   out_data  (red_out, green_out, blue_out, last_pixel)
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (0 image_width, 1 image_height)
//
// A word that completes no window passes the registered row-store read and the shift;
// one that completes a window then passes the window sum and the mean stage too.
// A finished word waits in the output register while the next input is taken.
// Once idle after a configuration write, the block recomputes the output position
// one quotient bit a cycle, and no input word is taken until that is done.
// Reset is synchronous and active low; the row stores are not cleared.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bb3_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bb3_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  bb3_pkg::bb3_cmd_t  cmd;
  bb3_pkg::bb3_stat_t stat;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  bb3_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  a_accept_blocks_next : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  a_cfg_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input offered straight after a configuration write");

  a_result_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while the block was idle");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bb3_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam int RANDOM_WORDS = 500;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam longint unsigned CYCLE_LIMIT = 150_000;

  class blur_scoreboard;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0] older_row [MAX_W];
    logic [PIX_W-1:0] newer_row [MAX_W];
    logic [PIX_W-1:0] window [9];
    int unsigned col, row, out_index;
    out_word_t expected_means [$];
    int unsigned mismatches, results_seen, images_seen;

    function new();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col = 0;
      row = 0;
      out_index = 0;
      mismatches = 0;
      results_seen = 0;
      images_seen = 0;
    endfunction

    function void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = value[CFG_HEIGHT_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction

    function bit at_image_start();
      return col == 0 && row == 0 && out_index == 0;
    endfunction

    function void take_word(input in_word_t word);
      int unsigned cols, rows, k, r, c, taps, total, dr, dc, ch;
      int unsigned chan_sum [3];
      logic [PIX_W-1:0] px, top, mid, tap;
      bit due;
      out_word_t mean;
      cols = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      rows = (height_reg == 0) ? 1 : height_reg;
      px = (word.kind == KIND_DRAIN) ? '0 : {word.blue_in, word.green_in, word.red_in};
      top = older_row[col % MAX_W];
      mid = newer_row[col % MAX_W];
      older_row[col % MAX_W] = mid;
      newer_row[col % MAX_W] = px;
      for (dr = 0; dr < 3; dr++) begin
        window[dr * 3] = window[dr * 3 + 1];
        window[dr * 3 + 1] = window[dr * 3 + 2];
      end
      window[2] = top;
      window[5] = mid;
      window[8] = px;
      due = row >= 2 || (row == 1 && col >= 1);
      if (col + 1 >= cols) begin
        col = 0;
        if (row < ROW_MAX) row++;
      end else begin
        col++;
      end
      if (!due) return;

      // The centre of the window sits in its middle row and middle column.
      k = out_index;
      r = k / cols;
      c = k % cols;
      taps = 0;
      chan_sum = '{0, 0, 0};
      for (dr = 0; dr < 3; dr++) begin
        for (dc = 0; dc < 3; dc++) begin
          if ((dr == 0 && r < 1) || (dr == 1 && r >= rows) || (dr == 2 && r + 1 >= rows))
            continue;
          if ((dc == 0 && c < 1) || (dc == 2 && c + 1 >= cols)) continue;
          tap = window[dr * 3 + dc];
          for (ch = 0; ch < 3; ch++) chan_sum[ch] += tap[ch * CH_W +: CH_W];
          taps++;
        end
      end
      mean.red_out = (taps != 0) ? CH_W'(chan_sum[0] / taps) : '0;
      mean.green_out = (taps != 0) ? CH_W'(chan_sum[1] / taps) : '0;
      mean.blue_out = (taps != 0) ? CH_W'(chan_sum[2] / taps) : '0;
      total = cols * rows;
      mean.last_pixel = (k + 1 >= total);
      if (mean.last_pixel) begin
        col = 0;
        row = 0;
        out_index = 0;
        images_seen++;
      end else begin
        out_index = (k + 1) % (1 << IDX_W);
      end
      expected_means.push_back(mean);
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH at result %0d: %s", results_seen, what);
    endtask

    task check_mean(input out_word_t got);
      out_word_t want;
      if (expected_means.size() == 0) begin
        report($sformatf("word %h arrived with nothing expected", got));
        return;
      end
      want = expected_means.pop_front();
      results_seen++;
      if (got.red_out !== want.red_out)
        report($sformatf("red %0d, expected %0d", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
        report($sformatf("green %0d, expected %0d", got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
        report($sformatf("blue %0d, expected %0d", got.blue_out, want.blue_out));
      if (got.last_pixel !== want.last_pixel)
        report($sformatf("last_pixel %0b, expected %0b", got.last_pixel, want.last_pixel));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blur_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int unsigned words_sent = 0;
  longint unsigned cycle_count = 0;

  box_blur_3x3_rgb i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_word_t random_word(input logic kind);
    in_word_t word;
    word.kind = kind;
    word.red_in = CH_W'($urandom_range(255));
    word.green_in = CH_W'($urandom_range(255));
    word.blue_in = CH_W'($urandom_range(255));
    return word;
  endfunction

  task automatic send_word(input in_word_t word);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_word(word);
    words_sent++;
  endtask

  task automatic send_image(input int unsigned cols, rows, drain_pct, stray_pct);
    int unsigned i;
    for (i = 0; i < cols * rows; i++)
      send_word(random_word(($urandom_range(99) < drain_pct) ? KIND_DRAIN : KIND_PIXEL));
    for (i = 0; i <= cols; i++)
      send_word(random_word(($urandom_range(99) < stray_pct) ? KIND_PIXEL : KIND_DRAIN));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_image(input logic [CFG_DATA_W-1:0] width_word, height_word);
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] value;
    int unsigned i;
    cfg_valid <= 1'b1;
    for (i = 0; i < 2; i++) begin
      idx = (i == 0) ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT;
      value = (i == 0) ? width_word : height_word;
      cfg_index <= idx;
      cfg_data <= value;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.apply_register(idx, value);
    end
    cfg_valid <= 1'b0;
  endtask

  // The image is resized part way through; the stream then runs on until the
  // scoreboard model expects the last output and starts afresh.
  task automatic restart_mid_image(input logic [CFG_DATA_W-1:0] w0, h0,
                                   input int unsigned prefix,
                                   input logic [CFG_DATA_W-1:0] w1, h1);
    int unsigned i;
    wait_idle();
    set_image(w0, h0);
    for (i = 0; i < prefix; i++) send_word(random_word(KIND_PIXEL));
    wait_idle();
    set_image(w1, h1);
    while (!sb.at_image_start())
      send_word(random_word(($urandom_range(3) == 0) ? KIND_PIXEL : KIND_DRAIN));
  endtask

  initial begin : receiver
    int unsigned stall;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 4);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_mean(out_data);
    end
  end

  initial begin : stimulus
    int unsigned i, n, start_words, cur_w, cur_h, first_w, first_h;
    logic [CFG_DATA_W-1:0] width_word, height_word;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_image(16'd2, 16'd2);
    send_word(in_word_t'{KIND_PIXEL, 8'h00, 8'h00, 8'h00});
    send_word(in_word_t'{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF});
    send_word(in_word_t'{KIND_PIXEL, 8'hFF, 8'h00, 8'hFF});
    send_word(in_word_t'{KIND_PIXEL, 8'h00, 8'hFF, 8'h00});
    send_word(in_word_t'{KIND_DRAIN, 8'hFF, 8'hFF, 8'hFF});
    send_word(in_word_t'{KIND_DRAIN, 8'hFF, 8'hFF, 8'hFF});
    send_word(in_word_t'{KIND_DRAIN, 8'h00, 8'h00, 8'h00});

    wait_idle();
    set_image(16'd0, 16'd0);
    send_word(in_word_t'{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF});
    send_word(in_word_t'{KIND_PIXEL, 8'h01, 8'h02, 8'h03});
    send_word(in_word_t'{KIND_DRAIN, 8'h80, 8'h40, 8'h20});

    wait_idle();
    set_image(16'd3, 16'd3);
    for (i = 0; i < 9; i++)
      send_word(in_word_t'{(i == 4) ? KIND_DRAIN : KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF});
    for (i = 0; i < 4; i++)
      send_word(in_word_t'{(i % 2 == 0) ? KIND_PIXEL : KIND_DRAIN, 8'hFF, 8'hFF, 8'hFF});

    restart_mid_image(16'd3, 16'hFFFF, 15, 16'd3, 16'd2);
    restart_mid_image(16'd4, 16'd4, 6, 16'd2, 16'd4);
    restart_mid_image(16'd2, 16'd3, 5, 16'd6, 16'd2);

    start_words = words_sent;
    hold_request = 1'b1;
    cur_w = 1;
    cur_h = 1;
    while (words_sent - start_words < RANDOM_WORDS) begin
      quiet = ($urandom_range(4) == 0);
      if ($urandom_range(9) == 0) begin
        first_w = $urandom_range(1, 8);
        first_h = $urandom_range(1, 6);
        cur_w = $urandom_range(1, 8);
        cur_h = $urandom_range(1, 6);
        restart_mid_image(CFG_DATA_W'(first_w), CFG_DATA_W'(first_h),
                          $urandom_range(first_w * first_h),
                          CFG_DATA_W'(cur_w), CFG_DATA_W'(cur_h));
      end else begin
        if (words_sent == start_words || $urandom_range(9) < 6) begin
          n = $urandom_range(19);
          cur_w = (n < 16) ? $urandom_range(1, 12) : ((n < 19) ? $urandom_range(13, 48) : 1);
          width_word = (n == 19) ? '0 : CFG_DATA_W'(cur_w);
          if ($urandom_range(3) == 0)
            width_word[CFG_DATA_W-1:CFG_WIDTH_W] = (CFG_DATA_W - CFG_WIDTH_W)'($urandom);
          cur_h = $urandom_range(1, 8);
          height_word = ($urandom_range(15) == 0) ? '0 : CFG_DATA_W'(cur_h);
          if (height_word == 0) cur_h = 1;
          wait_idle();
          set_image(width_word, height_word);
        end
        send_image(cur_w, cur_h, 4, 20);
      end
    end

    // An oversize width is clamped to the largest row; the image is then resized.
    quiet = 1'b0;
    restart_mid_image(16'hFFFF, 16'd1, 40, 16'd3, 16'd2);

    wait_idle();
    $display("Checked %0d blurred results from %0d input words across %0d images.",
             sb.results_seen, words_sent, sb.images_seen);
    $display("Widths ran from 1 to 48 plus a clamped oversize width, heights up to 65535, %s",
             "with mid-image resizing, black insertions and long output stalls.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_ctrl.sv
rtl/bb3_dp.sv
rtl/box_blur_3x3_rgb.sv
bench/tb_top.sv
